@@ rtl/core/lpr_pkg.sv @@
// ---------------------------------------------------------------------------
// LRU page replacement - shared definitions
// Sizes, the scan word carried along the frame cell chain and the update word broadcast to the cells.
// ---------------------------------------------------------------------------
package lpr_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int PAGE_BITS  = 8;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int CFG_W      = 4;
   localparam int MISS_W     = 16;

   // lookup word that walks down the chain, one cell per cycle
   typedef struct packed {
      logic                 active;
      logic [PAGE_BITS-1:0] page;
      logic                 hit;
      logic [IDX_W-1:0]     hit_idx;
      logic [IDX_W-1:0]     hit_rank;
      logic [IDX_W-1:0]     best_idx;
      logic [IDX_W-1:0]     best_rank;
      logic [PAGE_BITS-1:0] best_page;
   } scan_type;

   // broadcast to every cell when a reference is committed
   typedef struct packed {
      logic                 en;
      logic [IDX_W-1:0]     frame;
      logic                 write;
      logic                 age_all;
      logic [PAGE_BITS-1:0] page;
      logic [IDX_W-1:0]     old_rank;
   } upd_type;

endpackage

@@ rtl/core/lru_page_replacement.sv @@
// ---------------------------------------------------------------------------
// LRU page replacement unit
// Frame lookup over a chain of frame cells, then a commit that
// fills, refreshes or replaces a frame and reports the outcome.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_page
//  rsp     | out       | rsp_valid/rsp_stall | hit, frame_index, evicted_*, miss_count
//  csr     | in        | csr_valid/csr_ready | csr_data (frame count)
//
// A word passes the chain head register, then one frame cell per cycle, then the
// capture register and the commit, whose outcome is registered as the result. One
// word is in work at a time. Synchronous reset empties all frames, clears the miss
// count and sets the frame count to 4. A stalled result holds the commit; a new
// word is taken while the last result still waits.
module lru_page_replacement import lpr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PAGE_BITS-1:0] req_page,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [IDX_W-1:0]     rsp_frame_index,
   output logic                 rsp_evicted_valid,
   output logic [PAGE_BITS-1:0] rsp_evicted_page,
   output logic [MISS_W-1:0]    rsp_miss_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CFG_W-1:0]     cfg_ff;
   logic [CNT_W-1:0]     active_n;
   logic [CNT_W-1:0]     filled_ff;
   logic [MISS_W-1:0]    fault_ff, fault_in;
   scan_type             head_ff, head_in, dec_ff;
   scan_type             link [MAX_FRAMES+1];
   upd_type              upd;
   logic                 out_free, commit, fill, evict;
   logic [IDX_W-1:0]     frame_sel;

   logic                 rsp_valid_ff, rsp_hit_ff, rsp_ev_valid_ff;
   logic [IDX_W-1:0]     rsp_frame_ff;
   logic [PAGE_BITS-1:0] rsp_ev_page_ff;
   logic [MISS_W-1:0]    rsp_miss_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_W'(4);
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_data;
      end
   end

   always_comb begin
      if (cfg_ff == '0) begin
         active_n = CNT_W'(1);
      end else if (32'(cfg_ff) > MAX_FRAMES) begin
         active_n = CNT_W'(MAX_FRAMES);
      end else begin
         active_n = CNT_W'(cfg_ff);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      head_in        = '0;
      head_in.active = req_valid && !req_stall;
      head_in.page   = req_page;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   assign link[0] = head_ff;

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      lpr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .active_n (active_n),
         .scan_in  (link[i]),
         .scan_out (link[i+1]),
         .upd      (upd)
      );
   end

   always_ff @(posedge clock) begin
      if (link[MAX_FRAMES].active) begin
         dec_ff <= link[MAX_FRAMES];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = (state_ff == ST_DECIDE) && out_free;
   assign fill     = !dec_ff.hit && (filled_ff < active_n);
   assign evict    = !dec_ff.hit && !fill;

   always_comb begin
      if (dec_ff.hit) begin
         frame_sel = dec_ff.hit_idx;
      end else if (fill) begin
         frame_sel = filled_ff[IDX_W-1:0];
      end else begin
         frame_sel = dec_ff.best_idx;
      end
   end

   always_comb begin
      upd.en       = commit;
      upd.frame    = frame_sel;
      upd.write    = !dec_ff.hit;
      upd.age_all  = fill;
      upd.page     = dec_ff.page;
      upd.old_rank = dec_ff.hit ? dec_ff.hit_rank : dec_ff.best_rank;
   end

   assign fault_in = (!dec_ff.hit && fault_ff != '1) ? fault_ff + 1'b1 : fault_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (link[MAX_FRAMES].active) state_in = ST_DECIDE;
         ST_DECIDE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         filled_ff <= '0;
         fault_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            fault_ff <= fault_in;
            if (fill) begin
               filled_ff <= filled_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff      <= dec_ff.hit;
         rsp_frame_ff    <= frame_sel;
         rsp_ev_valid_ff <= evict;
         rsp_ev_page_ff  <= evict ? dec_ff.best_page : '0;
         rsp_miss_ff     <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_miss_count    = rsp_miss_ff;

   // a lookup word only enters the chain from idle
   a_head_from_idle: assert property (@(posedge clock) disable iff (reset)
      head_ff.active |-> $past(state_ff == ST_IDLE))
      else $error("lookup word entered chain outside idle");

   // the chain tail only fires while a lookup is outstanding
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      link[MAX_FRAMES].active |-> state_ff == ST_SCAN)
      else $error("chain tail active outside scan");

   // a new result appears only out of a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
      else $error("result raised without commit");

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      32'(filled_ff) <= MAX_FRAMES)
      else $error("filled frame count out of range");

   // a fill always targets the next free frame and grows the count by one
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      commit && fill |=> filled_ff == $past(filled_ff) + 1'b1)
      else $error("fill did not advance filled count");

endmodule

@@ rtl/core/lpr_cell.sv @@
// ---------------------------------------------------------------------------
// LRU page replacement - frame cell
// Holds one frame's page, valid bit and recency rank; folds its frame into
// the passing lookup word and registers it for the next cell.
// ---------------------------------------------------------------------------
module lpr_cell import lpr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic [CNT_W-1:0] active_n,
   input  scan_type         scan_in,
   output scan_type         scan_out,
   input  upd_type          upd
);

   logic [PAGE_BITS-1:0] page_ff;
   logic                 valid_ff;
   logic [IDX_W-1:0]     rank_ff;
   scan_type             scan_ff, scan_in_w;
   logic                 in_use, match;

   assign in_use = CNT_W'(cell_idx) < active_n;
   assign match  = valid_ff && in_use && (page_ff == scan_in.page);

   always_comb begin
      scan_in_w = scan_in;
      if (!scan_in.hit && match) begin
         scan_in_w.hit      = 1'b1;
         scan_in_w.hit_idx  = cell_idx;
         scan_in_w.hit_rank = rank_ff;
      end
      // frame 0 is always in use and seeds the oldest search
      if (in_use && (cell_idx == '0 || rank_ff > scan_in.best_rank)) begin
         scan_in_w.best_idx  = cell_idx;
         scan_in_w.best_rank = rank_ff;
         scan_in_w.best_page = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in_w;
      end
   end

   assign scan_out = scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else if (upd.en) begin
         if (upd.frame == cell_idx) begin
            rank_ff <= '0;
            if (upd.write) begin
               valid_ff <= 1'b1;
            end
         end else if (valid_ff && (upd.age_all || rank_ff < upd.old_rank)) begin
            rank_ff <= rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en && upd.write && upd.frame == cell_idx) begin
         page_ff <= upd.page;
      end
   end

endmodule
